// ===== rtl/plcs_pkg.sv =====
// Shared constants, result codes and the column valid-mask function
// for the projection-profile line and character segmenter. No dependencies.
`timescale 1ns / 1ps

package plcs_pkg;

  localparam int WORD_BITS  = 32;
  localparam int LOG_WORD   = $clog2(WORD_BITS);
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int NWORDS     = MAX_WIDTH / WORD_BITS;
  localparam int WIDX_BITS  = $clog2(NWORDS);
  localparam int WPR_BITS   = WIDX_BITS + 1;
  localparam int CFG_BITS   = 11;
  localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
  localparam int KIND_BITS  = 2;

  typedef enum logic [KIND_BITS-1:0] {
    CUT_TOP    = 2'd0,
    CUT_BOTTOM = 2'd1,
    CUT_MASK   = 2'd2
  } cut_kind_t;

  // Columns of word k that lie below width w.
  function automatic logic [WORD_BITS-1:0] valid_mask(input logic [CFG_BITS-1:0] w,
                                                      input logic [WIDX_BITS-1:0] k);
    logic [CFG_BITS:0]      base;
    logic [CFG_BITS:0]      rem;
    logic [WORD_BITS-1:0]   m;
    base = (CFG_BITS + 1)'(k) << LOG_WORD;
    rem  = (CFG_BITS + 1)'(w) - base;
    if (base >= (CFG_BITS + 1)'(w)) begin
      m = '0;
    end else if (rem >= (CFG_BITS + 1)'(WORD_BITS)) begin
      m = '1;
    end else begin
      m = (WORD_BITS'(1) << rem[LOG_WORD-1:0]) - WORD_BITS'(1);
    end
    return m;
  endfunction

endpackage

// ===== rtl/plcs_in_if.sv =====
// Pixel word channel: valid/ready handshake with frame start flag and pixels.
// Depends on plcs_pkg.
`timescale 1ns / 1ps

interface plcs_in_if;
  logic                           valid;
  logic                           ready;
  logic                           start_of_frame;
  logic [plcs_pkg::WORD_BITS-1:0] pixel_word;

  modport source (output valid, output start_of_frame, output pixel_word, input ready);
  modport sink   (input valid, input start_of_frame, input pixel_word, output ready);
endinterface

// ===== rtl/plcs_out_if.sv =====
// Cut result channel: valid/ready handshake with line cuts and column cut masks.
// Depends on plcs_pkg.
`timescale 1ns / 1ps

interface plcs_out_if;
  logic                           valid;
  logic                           ready;
  logic [plcs_pkg::KIND_BITS-1:0] cut_kind;
  logic [plcs_pkg::ROW_BITS-1:0]  cut_row;
  logic [plcs_pkg::WIDX_BITS-1:0] mask_word_index;
  logic [plcs_pkg::WORD_BITS-1:0] cut_mask;
  logic                           last_of_run;

  modport source (output valid, output cut_kind, output cut_row, output mask_word_index,
                  output cut_mask, output last_of_run, input ready);
  modport sink   (input valid, input cut_kind, input cut_row, input mask_word_index,
                  input cut_mask, input last_of_run, output ready);
endinterface

// ===== rtl/plcs_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// Read during write to the same address returns the old contents.
`timescale 1ns / 1ps

module plcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/projection_line_char_segmenter.sv =====
// Projection-profile line and character segmenter, top level.
// Depends on plcs_pkg, plcs_in_if, plcs_out_if and plcs_ram.
`timescale 1ns / 1ps
//
//   channel   dir  kind           words
//   words     in   valid/ready    start_of_frame, pixel_word
//   cuts      out  valid/ready    cut_kind, cut_row, mask_word_index, cut_mask, last_of_run
//   cfg       in   write enable   image_width (cfg_data)
//
// One pixel word per cycle when input is not held; each word does a read-modify-write
// of the column-OR RAM, with the write in the cycle after the read and forwarding
// between back-to-back words. A closing band stops input while the readout runs: it
// alternates issuing a RAM read with using its data, emitting one mask word per row word.
// A row-ending word waits while the result register is full and not taken.
// Synchronous reset; column store validity is per-entry flops, so no clearing pass.

module projection_line_char_segmenter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [plcs_pkg::CFG_BITS-1:0] cfg_data,
  plcs_in_if.sink                       words,
  plcs_out_if.source                    cuts
);

  localparam int WB = plcs_pkg::WORD_BITS;
  localparam int IB = plcs_pkg::WIDX_BITS;
  localparam int PB = plcs_pkg::WPR_BITS;
  localparam int CB = plcs_pkg::CFG_BITS;
  localparam int RB = plcs_pkg::ROW_BITS;

  typedef enum logic {ST_RUN, ST_READ} state_t;

  state_t                 state;
  logic [CB-1:0]          image_width;
  logic [IB-1:0]          wc;
  logic [RB-1:0]          row;
  logic                   prev_ink;
  logic                   row_ink;
  logic [plcs_pkg::NWORDS-1:0] valid_bits;

  logic                   s1_valid;
  logic [IB-1:0]          s1_addr;
  logic [WB-1:0]          s1_px;

  logic                   fwd_hit;
  logic [WB-1:0]          fwd_data;
  logic                   vld_q;
  logic                   rd_zero;

  logic [PB-1:0]          rd_j;
  logic                   rd_pend;
  logic [RB-1:0]          band_row;
  logic [WB-1:0]          win_cur;
  logic                   win_msb;

  logic                   out_valid;
  plcs_pkg::cut_kind_t    out_kind;
  logic [RB-1:0]          out_row;
  logic [IB-1:0]          out_idx;
  logic [WB-1:0]          out_mask;
  logic                   out_last;

  logic [CB-1:0]          w_eff;
  logic [CB-1:0]          w_sum;
  logic [PB-1:0]          wpr;
  logic                   accept;
  logic                   sof;
  logic [IB-1:0]          wi;
  logic [WB-1:0]          px;
  logic                   ink_eff;
  logic                   prev_eff;
  logic [RB-1:0]          row_eff;
  logic [PB-1:0]          wc_inc;
  logic                   row_end;
  logic                   top_cut;
  logic                   bottom_cut;
  logic                   out_free;
  logic                   next_ends_row;

  logic                   ram_we;
  logic [WB-1:0]          ram_wdata;
  logic [IB-1:0]          ram_raddr;
  logic [WB-1:0]          ram_rdata;
  logic [WB-1:0]          rd_eff;

  logic [IB-1:0]          rk;
  logic [WB-1:0]          rd_word;
  logic [WB-1:0]          left_nb;
  logic [WB-1:0]          right_nb;
  logic [WB-1:0]          cut_word;

  always_comb begin
    if (image_width == '0) begin
      w_eff = CB'(1);
    end else if (image_width > CB'(plcs_pkg::MAX_WIDTH)) begin
      w_eff = CB'(plcs_pkg::MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
  end

  assign w_sum = w_eff + CB'(WB - 1);
  assign wpr   = w_sum[CB-1:plcs_pkg::LOG_WORD];

  assign out_free      = !out_valid || cuts.ready;
  assign next_ends_row = (PB'(wc) + PB'(1)) >= wpr;
  assign words.ready   = (state == ST_RUN) && (out_free || !next_ends_row);
  assign accept        = words.valid && words.ready;

  assign sof        = words.start_of_frame;
  assign wi         = sof ? '0 : wc;
  assign px         = words.pixel_word & plcs_pkg::valid_mask(w_eff, wi);
  assign ink_eff    = (sof ? 1'b0 : row_ink) | (|px);
  assign prev_eff   = sof ? 1'b0 : prev_ink;
  assign row_eff    = sof ? '0 : row;
  assign wc_inc     = PB'(wi) + PB'(1);
  assign row_end    = wc_inc >= wpr;
  assign top_cut    = row_end && ink_eff && !prev_eff && (row_eff != '0);
  assign bottom_cut = row_end && !ink_eff && prev_eff;

  // read data of the previous cycle, corrected for a same-entry write, validity and start of frame
  always_comb begin
    if (rd_zero) begin
      rd_eff = '0;
    end else if (fwd_hit) begin
      rd_eff = fwd_data;
    end else if (vld_q) begin
      rd_eff = ram_rdata;
    end else begin
      rd_eff = '0;
    end
  end

  assign ram_we    = s1_valid;
  assign ram_wdata = rd_eff | s1_px;
  assign ram_raddr = (state == ST_RUN) ? wi : rd_j[IB-1:0];

  plcs_ram #(
    .WIDTH (WB),
    .DEPTH (plcs_pkg::NWORDS)
  ) u_col_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // readout window: win_cur is word rk, rd_word is word rk + 1
  assign rk       = IB'(rd_j - PB'(1));
  assign rd_word  = (rd_j < wpr) ? (rd_eff & plcs_pkg::valid_mask(w_eff, rd_j[IB-1:0])) : '0;
  assign left_nb  = {win_cur[WB-2:0], win_msb};
  assign right_nb = {rd_word[0], win_cur[WB-1:1]};
  assign cut_word = ~win_cur & (left_nb | right_nb) & plcs_pkg::valid_mask(w_eff, rk);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_RUN;
      image_width <= CB'(plcs_pkg::MAX_WIDTH);
      wc          <= '0;
      row         <= '0;
      prev_ink    <= 1'b0;
      row_ink     <= 1'b0;
      valid_bits  <= '0;
      s1_valid    <= 1'b0;
      fwd_hit     <= 1'b0;
      vld_q       <= 1'b0;
      rd_zero     <= 1'b0;
      rd_j        <= '0;
      rd_pend     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        image_width <= cfg_data;
      end

      s1_valid <= accept;
      fwd_hit  <= s1_valid && (s1_addr == ram_raddr);
      vld_q    <= valid_bits[ram_raddr];
      rd_zero  <= accept && sof;

      if (s1_valid) begin
        valid_bits[s1_addr] <= 1'b1;
      end
      if (accept && sof) begin
        valid_bits <= '0;
      end

      if (cuts.valid && cuts.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_RUN: begin
          if (accept) begin
            if (row_end) begin
              wc       <= '0;
              prev_ink <= ink_eff;
              row_ink  <= 1'b0;
              row      <= row_eff + RB'(1);
            end else begin
              wc       <= wc_inc[IB-1:0];
              prev_ink <= prev_eff;
              row_ink  <= ink_eff;
              row      <= row_eff;
            end
            if (top_cut) begin
              out_valid <= 1'b1;
              out_kind  <= plcs_pkg::CUT_TOP;
              out_row   <= row_eff - RB'(1);
              out_idx   <= '0;
              out_mask  <= '0;
              out_last  <= 1'b1;
            end
            if (bottom_cut) begin
              out_valid <= 1'b1;
              out_kind  <= plcs_pkg::CUT_BOTTOM;
              out_row   <= row_eff;
              out_idx   <= '0;
              out_mask  <= '0;
              out_last  <= 1'b0;
              state     <= ST_READ;
              rd_j      <= '0;
              rd_pend   <= 1'b0;
              win_cur   <= '0;
              win_msb   <= 1'b0;
              band_row  <= row_eff;
            end
          end
        end
        ST_READ: begin
          if (!rd_pend) begin
            if (out_free) begin
              rd_pend <= 1'b1;
            end
          end else begin
            rd_pend <= 1'b0;
            win_cur <= rd_word;
            win_msb <= win_cur[WB-1];
            rd_j    <= rd_j + PB'(1);
            if (rd_j != '0) begin
              out_valid <= 1'b1;
              out_kind  <= plcs_pkg::CUT_MASK;
              out_row   <= band_row;
              out_idx   <= rk;
              out_mask  <= cut_word;
              out_last  <= (rd_j == wpr);
            end
            if (rd_j == wpr) begin
              state      <= ST_RUN;
              valid_bits <= '0;
            end
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    s1_addr  <= wi;
    s1_px    <= px;
    fwd_data <= ram_wdata;
  end

  assign cuts.valid           = out_valid;
  assign cuts.cut_kind        = out_kind;
  assign cuts.cut_row         = out_row;
  assign cuts.mask_word_index = out_idx;
  assign cuts.cut_mask        = out_mask;
  assign cuts.last_of_run     = out_last;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for projection_line_char_segmenter: drives pixel words over
// the input channel, predicts line cuts and column cut masks, checks every cut word.
// Depends on plcs_pkg, plcs_in_if, plcs_out_if and the segmenter RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int WORD_BITS      = plcs_pkg::WORD_BITS;
  localparam int NWORDS         = plcs_pkg::NWORDS;
  localparam int WIDX_BITS      = plcs_pkg::WIDX_BITS;
  localparam int ROW_BITS       = plcs_pkg::ROW_BITS;
  localparam int CFG_BITS       = plcs_pkg::CFG_BITS;
  localparam int MAX_WIDTH      = plcs_pkg::MAX_WIDTH;
  localparam int DRAIN_CYCLES   = 2 * (NWORDS + 1) + 33;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef enum {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic                 sof;
    logic [WORD_BITS-1:0] pix;
  } word_item_t;

  typedef struct packed {
    plcs_pkg::cut_kind_t  kind;
    logic [ROW_BITS-1:0]  row;
    logic [WIDX_BITS-1:0] idx;
    logic [WORD_BITS-1:0] mask;
    logic                 last;
  } cut_item_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_BITS-1:0]  cfg_data = '0;
  logic                 tx_valid = 1'b0;
  logic                 tx_sof = 1'b0;
  logic [WORD_BITS-1:0] tx_word = '0;
  logic                 rx_ready = 1'b0;

  plcs_in_if  pix_if ();
  plcs_out_if cut_if ();

  assign pix_if.valid          = tx_valid;
  assign pix_if.start_of_frame = tx_sof;
  assign pix_if.pixel_word     = tx_word;
  assign cut_if.ready          = rx_ready;

  projection_line_char_segmenter dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .words    (pix_if),
    .cuts     (cut_if)
  );

  initial forever #4 clk = ~clk;

  word_item_t words_todo[$];
  cut_item_t  cuts_due[$];
  int         errors = 0;
  int         tx_idle_pct = 0;
  int         rx_stall_pct = 0;
  int         hold_reqs = 0;
  int         hold_done = 0;
  int         hold_left = 0;
  int         stall_cycles = 0;

  // segmenter image
  logic [CFG_BITS-1:0]  cur_width = CFG_BITS'(MAX_WIDTH);
  logic [WORD_BITS-1:0] ink_or [NWORDS];
  logic                 prev_row_ink = 1'b0;
  logic                 cur_row_ink = 1'b0;
  logic [ROW_BITS-1:0]  row_idx = '0;
  int                   word_idx = 0;

  initial for (int k = 0; k < NWORDS; k++) ink_or[k] = '0;

  function automatic int eff_width();
    int w;
    w = int'(cur_width);
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int row_words();
    return (eff_width() + WORD_BITS - 1) / WORD_BITS;
  endfunction

  function automatic logic [WORD_BITS-1:0] col_valid(input int k);
    int w;
    int base;
    int rem;
    w = eff_width();
    base = k * WORD_BITS;
    if (base >= w) return '0;
    rem = w - base;
    if (rem >= WORD_BITS) return '1;
    return (WORD_BITS'(1) << rem) - WORD_BITS'(1);
  endfunction

  task automatic segment_word(input logic sof, input logic [WORD_BITS-1:0] pw);
    int                   wpr;
    int                   wi;
    int                   nres;
    logic [WORD_BITS-1:0] px;
    logic [WORD_BITS-1:0] ink;
    logic [WORD_BITS-1:0] nbr;
    logic [WORD_BITS-1:0] side;
    logic [WORD_BITS-1:0] cut;
    wpr = row_words();
    if (sof) begin
      for (int k = 0; k < NWORDS; k++) ink_or[k] = '0;
      prev_row_ink = 1'b0;
      cur_row_ink = 1'b0;
      row_idx = '0;
      word_idx = 0;
    end
    wi = (word_idx > NWORDS - 1) ? NWORDS - 1 : word_idx;
    px = pw & col_valid(wi);
    if (px != '0) cur_row_ink = 1'b1;
    ink_or[wi] = ink_or[wi] | px;
    word_idx++;
    if (word_idx >= wpr) begin
      word_idx = 0;
      if (cur_row_ink && !prev_row_ink) begin
        if (row_idx != '0)
          cuts_due.push_back('{kind: plcs_pkg::CUT_TOP, row: row_idx - 1'b1, idx: '0,
                               mask: '0, last: 1'b1});
      end else if (!cur_row_ink && prev_row_ink) begin
        nres = (wpr < NWORDS) ? wpr : NWORDS;
        cuts_due.push_back('{kind: plcs_pkg::CUT_BOTTOM, row: row_idx, idx: '0, mask: '0,
                             last: 1'b0});
        for (int k = 0; k < nres; k++) begin
          ink = ink_or[k] & col_valid(k);
          nbr = (ink << 1) | (ink >> 1);
          if (k > 0) begin
            side = ink_or[k-1] & col_valid(k - 1);
            nbr[0] = nbr[0] | side[WORD_BITS-1];
          end
          if (k + 1 < NWORDS) begin
            side = ink_or[k+1] & col_valid(k + 1);
            nbr[WORD_BITS-1] = nbr[WORD_BITS-1] | side[0];
          end
          cut = ~ink & nbr & col_valid(k);
          cuts_due.push_back('{kind: plcs_pkg::CUT_MASK, row: row_idx, idx: WIDX_BITS'(k),
                               mask: cut, last: (k == nres - 1)});
        end
        for (int k = 0; k < NWORDS; k++) ink_or[k] = '0;
      end
      prev_row_ink = cur_row_ink;
      cur_row_ink = 1'b0;
      row_idx = row_idx + 1'b1;
    end
  endtask

  task automatic check_cut();
    cut_item_t want;
    if (cuts_due.size() == 0) begin
      $display("%0t unexpected cut word: kind %0d row %0d idx %0d mask %h last %b", $time,
               cut_if.cut_kind, cut_if.cut_row, cut_if.mask_word_index, cut_if.cut_mask,
               cut_if.last_of_run);
      errors++;
    end else begin
      want = cuts_due.pop_front();
      if (cut_if.cut_kind !== want.kind || cut_if.cut_row !== want.row ||
          cut_if.mask_word_index !== want.idx || cut_if.cut_mask !== want.mask ||
          cut_if.last_of_run !== want.last) begin
        $display("%0t cut mismatch: expected kind %0d row %0d idx %0d mask %h last %b",
                 $time, want.kind, want.row, want.idx, want.mask, want.last);
        $display("%0t               actual   kind %0d row %0d idx %0d mask %h last %b",
                 $time, cut_if.cut_kind, cut_if.cut_row, cut_if.mask_word_index,
                 cut_if.cut_mask, cut_if.last_of_run);
        errors++;
      end
    end
  endtask

  // driver
  always @(posedge clk) begin : drive
    word_item_t it;
    if (rst) begin
      tx_valid <= 1'b0;
    end else if (!tx_valid || pix_if.ready) begin
      if (words_todo.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        it = words_todo.pop_front();
        tx_valid <= 1'b1;
        tx_sof <= it.sof;
        tx_word <= it.pix;
      end else begin
        tx_valid <= 1'b0;
      end
    end
  end

  // receiver, with long hold-offs on request
  always @(posedge clk) begin
    if (hold_reqs != hold_done) begin
      hold_done <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      rx_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rx_ready <= 1'b0;
    end else begin
      rx_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (tx_valid && pix_if.ready) segment_word(tx_sof, tx_word);
      if (cut_if.valid && rx_ready) check_cut();
    end
  end

  always @(posedge clk) begin
    if ((tx_valid && pix_if.ready) || (cut_if.valid && rx_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t no handshake for %0d cycles", $time, stall_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic push_word(input logic sof, input logic [WORD_BITS-1:0] pw);
    words_todo.push_back('{sof: sof, pix: pw});
  endtask

  task automatic set_width(input int w);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= CFG_BITS'(w);
    cur_width = CFG_BITS'(w);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_idle(input idle_mode_t m);
    tx_idle_pct  = (m == IDLE_TX || m == IDLE_RX) ? ((m == IDLE_TX) ? 75 : 0) :
                   ((m == IDLE_BOTH) ? 11 : 0);
    rx_stall_pct = (m == IDLE_RX) ? 75 : ((m == IDLE_BOTH) ? 11 : 0);
  endtask

  task automatic wait_quiet();
    do @(negedge clk); while (words_todo.size() != 0 || tx_valid || cuts_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [WORD_BITS-1:0] ink_pattern();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return WORD_BITS'(1) << $urandom_range(WORD_BITS - 1);
      2:       return $urandom & $urandom & $urandom;
      default: return ~($urandom & $urandom);
    endcase
  endfunction

  // frames of random bands; some cut short, some noise bursts
  task automatic gen_phase(input int budget);
    int                   n;
    int                   wpr;
    int                   rows;
    int                   stop_at;
    int                   w;
    logic                 inked;
    logic [WORD_BITS-1:0] pw;
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++) push_word(1'b0, $urandom);
    while (n < budget) begin
      wpr = row_words();
      rows = (wpr <= 4) ? $urandom_range(2, 10) : $urandom_range(2, 4);
      stop_at = ($urandom_range(9) == 0) ? $urandom_range(1, rows * wpr - 1) : rows * wpr;
      inked = 1'b0;
      for (int i = 0; i < stop_at; i++) begin
        w = i % wpr;
        if (w == 0) inked = $urandom_range(1);
        if (inked) pw = ink_pattern();
        else pw = ($urandom_range(3) == 0) ? ($urandom & ~col_valid(w)) : '0;
        push_word(i == 0, pw);
      end
      n += stop_at;
      if ($urandom_range(19) == 0) begin
        for (int i = 0; i < 4; i++) push_word($urandom_range(3) == 0, $urandom);
        n += 4;
      end
    end
  endtask

  initial begin : main
    int w;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // two words per row; band at row 0, extremes, pixels past width, open band at frame end
    set_width(40);
    set_idle(IDLE_NONE);
    push_word(1'b1, 32'h0000_0001);
    push_word(1'b0, 32'h0000_00FF);
    push_word(1'b0, 32'h0000_0000);
    push_word(1'b0, 32'h0000_0000);
    push_word(1'b0, 32'h0000_0000);
    push_word(1'b0, 32'h0000_0000);
    push_word(1'b0, 32'hFFFF_FFFF);
    push_word(1'b0, 32'hFFFF_FFFF);
    push_word(1'b0, 32'h8000_0001);
    push_word(1'b0, 32'h0000_0080);
    push_word(1'b0, 32'h0000_0000);
    push_word(1'b0, 32'h0000_0000);
    push_word(1'b0, 32'h0000_0000);
    push_word(1'b0, 32'hFFFF_FF00);
    push_word(1'b0, 32'h0001_0000);
    push_word(1'b0, 32'h0000_0000);
    push_word(1'b1, 32'h0000_0000);
    push_word(1'b0, 32'h0000_0000);
    push_word(1'b0, 32'h5555_5555);
    push_word(1'b0, 32'hAAAA_AAAA);
    push_word(1'b0, 32'h0000_0000);
    push_word(1'b0, 32'h0000_0000);
    push_word(1'b0, 32'h1234_5678);
    wait_quiet();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0:       w = 1;
        1:       w = 0;
        2:       w = 33;
        3:       w = MAX_WIDTH;
        4:       w = $urandom_range(2, 96);
        5:       w = 31;
        6:       w = 32;
        7:       w = $urandom_range(97, 2047);
        default: w = $urandom_range(2, 64);
      endcase
      set_width(w);
      set_idle(idle_mode_t'(ph % 4));
      gen_phase(30);
      wait_quiet();
    end

    // receiver holds off while a full-width band closes
    set_width(2047);
    set_idle(IDLE_NONE);
    hold_reqs++;
    for (int i = 0; i < 2 * NWORDS; i++)
      push_word(i == 0, ((i / NWORDS) % 2 == 0) ? ink_pattern() | 32'h1 : 32'h0);
    wait_quiet();

    if (errors == 0 && cuts_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (cuts_due.size() != 0)
        $display("%0t %0d expected cut words never arrived", $time, cuts_due.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/plcs_pkg.sv
rtl/plcs_in_if.sv
rtl/plcs_out_if.sv
rtl/plcs_ram.sv
rtl/projection_line_char_segmenter.sv
tb/tb_top.sv
